>>> hw/rtl/sparse_bayes_mean_field_solver_core_macros.svh
// Assertion macros shared by the checker of the mean-field solver core.
// No dependencies.
`ifndef SPARSE_BAYES_MEAN_FIELD_SOLVER_CORE_MACROS_SVH
`define SPARSE_BAYES_MEAN_FIELD_SOLVER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SBMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SBMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/sbmf_pkg.sv
// Shared types, constants and fixed-point helpers for the mean-field solver core.
// No dependencies.
`default_nettype none
package sbmf_pkg;
    localparam int MEAS_ROWS   = 32;
    localparam int WEIGHT_COLS = 16;
    localparam int ROW_W  = $clog2(MEAS_ROWS);
    localparam int COL_W  = $clog2(WEIGHT_COLS);
    localparam int MAT_DEPTH = MEAS_ROWS * WEIGHT_COLS;
    localparam int MAT_AW = $clog2(MAT_DEPTH);
    localparam int GRAM_DEPTH = WEIGHT_COLS * WEIGHT_COLS;
    localparam int GRAM_AW = $clog2(GRAM_DEPTH);
    // 32 floored products of up to 2^46 each need 53 bits signed
    localparam int ACC_W = 56;

    localparam logic [1:0] REQ_MATRIX = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam logic [2:0] CFG_WSHAPE = 3'd0;
    localparam logic [2:0] CFG_WRATE  = 3'd1;
    localparam logic [2:0] CFG_NSHAPE = 3'd2;
    localparam logic [2:0] CFG_NRATE  = 3'd3;
    localparam logic [2:0] CFG_SWEEPS = 3'd4;

    localparam logic signed [31:0] QONE  = 32'sd65536;
    localparam logic signed [31:0] QMAXV = 32'sh7fffffff;
    localparam logic signed [31:0] QMINV = 32'sh80000000;

    typedef struct packed {
        logic                start;
        logic signed [31:0]  num;
        logic signed [31:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic signed [31:0]  quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat48(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(ACC_W-32){1'b0}}, QMAXV})) r = QMAXV;
        else if (x < $signed({{(ACC_W-32){1'b1}}, QMINV})) r = QMINV;
        else r = x[31:0];
        return r;
    endfunction

    // floor of the product shifted by 16; arithmetic shift floors
    function automatic logic signed [ACC_W-1:0] pmul(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [31:0] qhalf(input logic signed [31:0] a);
        return a >>> 1;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/sparse_bayes_mean_field_solver_core.sv
// Mean-field sparse Bayesian learning solver over a 32x16 matrix, Q16.16 saturating.
// Loads (matrix, data) are accepted back to back while idle. A start transaction holds
// the input off while one shared 32x32 multiplier with a 56-bit accumulator and one
// serial divider run Gram setup and then each sweep (33 divides plus other steps,
// mostly multiply-accumulate at one per cycle after a registered memory read);
// afterward the 32 results stream out, one per cycle when taken.
`default_nettype none
module sparse_bayes_mean_field_solver_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // req_type, row_index, col_index, load_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // weight_index, result_value, pad
    output logic             m_axis_tuser,  // result_kind
    output logic             m_axis_tlast   // last_result
);
    import sbmf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT_DIV, S_INIT_WAIT,
        S_GRAM, S_GRAM_WR, S_PROJ, S_PROJ_WR,
        S_V_MUL, S_V_DIV, S_V_WAIT, S_OFF, S_M_MUL1, S_M_MUL2,
        S_X_MUL, S_X_DIV, S_X_WAIT,
        S_R_ACC, S_R_SQ, S_TR, S_N_DIV, S_N_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [30:0] wshape_reg, wrate_reg, nshape_reg, nrate_reg;
    logic [9:0]  sweeps_reg;

    logic [1:0]  req_type;
    logic [ROW_W-1:0] row_in;
    logic [COL_W-1:0] col_in;
    logic [31:0] load_value;
    assign req_type   = s_axis_tdata[1:0];
    assign row_in     = s_axis_tdata[6:2];
    assign col_in     = s_axis_tdata[10:7];
    assign load_value = s_axis_tdata[42:11];

    // counters
    logic [COL_W-1:0] i_reg, j_reg;
    logic [ROW_W:0]   k_reg;   // inner step count incl. the registered read
    logic [9:0]       sw_reg;
    logic             phase_reg;

    logic signed [ACC_W-1:0] acc_reg, acc2_reg;
    logic signed [31:0] tau_reg, t1_reg, v_reg;
    logic signed [31:0] xi_reg [WEIGHT_COLS];
    logic signed [31:0] mean_reg [WEIGHT_COLS];
    logic signed [31:0] var_reg [WEIGHT_COLS];
    logic signed [31:0] proj_reg [WEIGHT_COLS];
    logic signed [31:0] adiag_reg [WEIGHT_COLS];
    logic signed [31:0] alpha_reg, nu_reg;

    // memories
    logic              mat_we, dat_we, gram_we;
    logic [MAT_AW-1:0] mat_addr;
    logic [ROW_W-1:0]  dat_addr;
    logic [GRAM_AW-1:0] gram_addr;
    logic [31:0]       mat_rd, dat_rd, gram_rd, gram_wd;
    logic [31:0]       mat_rd2_reg;  // first operand captured for Gram

    sbmf_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat (
        .clk(clk), .we(mat_we), .addr(mat_addr), .wdata(load_value), .rdata(mat_rd));
    sbmf_ram #(.WIDTH(32), .DEPTH(MEAS_ROWS)) u_dat (
        .clk(clk), .we(dat_we), .addr(dat_addr), .wdata(load_value), .rdata(dat_rd));
    sbmf_ram #(.WIDTH(32), .DEPTH(GRAM_DEPTH)) u_gram (
        .clk(clk), .we(gram_we), .addr(gram_addr), .wdata(gram_wd), .rdata(gram_rd));

    div_req_t dreq;
    div_rsp_t drsp;
    sbmf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [ACC_W-1:0] pfl;
    logic signed [31:0] psat;
    assign prod = mul_a * mul_b;
    assign pfl  = pmul(prod);
    assign psat = sat48(pfl);

    logic in_fire;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Gram/ctrl: GRAM and PROJ read a column per row; Gram uses two reads per row (phase)
    logic [ROW_W-1:0] row_cur;
    assign row_cur = k_reg[ROW_W-1:0];

    always_comb
    begin
        mat_we = 1'b0; dat_we = 1'b0; gram_we = 1'b0;
        mat_addr = {row_in, col_in};
        dat_addr = row_in;
        gram_addr = {i_reg, j_reg};
        gram_wd = sat48(acc_reg);
        mul_a = '0; mul_b = '0;
        dreq.start = 1'b0; dreq.num = '0; dreq.den = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                mat_we = in_fire && (req_type == REQ_MATRIX);
                dat_we = in_fire && (req_type == REQ_DATA);
            end
            S_GRAM:
            begin
                mat_addr = {row_cur, phase_reg ? j_reg : i_reg};
                mul_a = mat_rd2_reg; mul_b = mat_rd;
            end
            S_GRAM_WR: gram_we = 1'b1;
            S_PROJ:
            begin
                mat_addr = {row_cur, i_reg};
                dat_addr = row_cur;
                mul_a = mat_rd; mul_b = dat_rd;
            end
            S_INIT_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num = phase_reg ? {1'b0, nshape_reg} : {1'b0, wshape_reg};
                dreq.den = phase_reg ? {1'b0, nrate_reg} : {1'b0, wrate_reg};
            end
            S_V_MUL: begin mul_a = tau_reg; mul_b = adiag_reg[i_reg]; end
            S_V_DIV:
            begin
                dreq.start = 1'b1; dreq.num = QONE;
                dreq.den = sat48(ACC_W'(xi_reg[i_reg]) + ACC_W'(t1_reg));
            end
            S_OFF:
            begin
                gram_addr = {i_reg, j_reg};
                mul_a = gram_rd; mul_b = mean_reg[j_reg - COL_W'(1)];
            end
            S_M_MUL1: begin mul_a = tau_reg; mul_b = v_reg; end
            S_M_MUL2:
            begin
                mul_a = t1_reg;
                mul_b = sat48(ACC_W'(proj_reg[i_reg]) - ACC_W'(sat48(acc_reg)));
            end
            S_X_MUL: begin mul_a = mean_reg[i_reg]; mul_b = mean_reg[i_reg]; end
            S_X_DIV:
            begin
                dreq.start = 1'b1; dreq.num = alpha_reg;
                dreq.den = sat48(ACC_W'({1'b0, wrate_reg}) + ACC_W'(qhalf(t1_reg)));
            end
            S_R_ACC:
            begin
                mat_addr = {row_cur, j_reg};
                dat_addr = row_cur;
                mul_a = mat_rd; mul_b = mean_reg[j_reg - COL_W'(1)];
            end
            S_R_SQ: begin mul_a = t1_reg; mul_b = t1_reg; end
            S_TR: begin mul_a = adiag_reg[i_reg]; mul_b = var_reg[i_reg]; end
            S_N_DIV:
            begin
                dreq.start = 1'b1; dreq.num = nu_reg;
                dreq.den = t1_reg;
            end
            default: ;
        endcase
    end

    logic signed [31:0] lam1;
    assign lam1 = sat48(ACC_W'({1'b0, nrate_reg}) + ACC_W'(qhalf(sat48(acc2_reg))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wshape_reg <= 31'd65536;
            wrate_reg  <= 31'd65536;
            nshape_reg <= 31'd65536;
            nrate_reg  <= 31'd65536;
            sweeps_reg <= 10'd64;
            m_axis_tvalid <= 1'b0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; sw_reg <= '0; phase_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WSHAPE: wshape_reg <= cfg_data;
                    CFG_WRATE:  wrate_reg  <= cfg_data;
                    CFG_NSHAPE: nshape_reg <= cfg_data;
                    CFG_NRATE:  nrate_reg  <= cfg_data;
                    CFG_SWEEPS: sweeps_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_fire && req_type == REQ_START)
                    begin
                        alpha_reg <= sat48(ACC_W'({1'b0, wshape_reg}) + ACC_W'(32'sd32768));
                        nu_reg <= sat48(ACC_W'({1'b0, nshape_reg})
                                  + ACC_W'(32768 * MEAS_ROWS));
                        i_reg <= '0; j_reg <= '0; k_reg <= '0; phase_reg <= 1'b0;
                        acc_reg <= '0;
                        state_reg <= S_GRAM;
                    end
                // two reads per row: phase 0 fetches column i, phase 1 column j
                S_GRAM:
                begin
                    if (phase_reg) mat_rd2_reg <= mat_rd;  // column i data arrives
                    if (!phase_reg && k_reg != '0)
                        acc_reg <= acc_reg + pfl;          // mat_rd holds column j
                    if (phase_reg)
                    begin
                        phase_reg <= 1'b0;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (k_reg == (ROW_W+1)'(MEAS_ROWS))
                        state_reg <= S_GRAM_WR;
                    else
                        phase_reg <= 1'b1;
                end
                S_GRAM_WR:
                begin
                    if (i_reg == j_reg) adiag_reg[i_reg] <= sat48(acc_reg);
                    acc_reg <= '0; k_reg <= '0;
                    if (j_reg == COL_W'(WEIGHT_COLS - 1))
                    begin
                        j_reg <= '0; state_reg <= S_PROJ;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1; state_reg <= S_GRAM;
                    end
                end
                S_PROJ:
                begin
                    if (k_reg != '0) acc_reg <= acc_reg + pfl;
                    if (k_reg == (ROW_W+1)'(MEAS_ROWS)) state_reg <= S_PROJ_WR;
                    k_reg <= k_reg + 1'b1;
                end
                S_PROJ_WR:
                begin
                    proj_reg[i_reg] <= sat48(acc_reg);
                    mean_reg[i_reg] <= '0;
                    var_reg[i_reg]  <= QONE;
                    acc_reg <= '0; k_reg <= '0;
                    if (i_reg == COL_W'(WEIGHT_COLS - 1))
                    begin
                        i_reg <= '0; phase_reg <= 1'b0; state_reg <= S_INIT_DIV;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1; state_reg <= S_GRAM;
                    end
                end
                S_INIT_DIV: state_reg <= S_INIT_WAIT;
                S_INIT_WAIT:
                    if (drsp.done)
                    begin
                        if (!phase_reg)
                        begin
                            for (int n = 0; n < WEIGHT_COLS; n++) xi_reg[n] <= drsp.quo;
                            phase_reg <= 1'b1; state_reg <= S_INIT_DIV;
                        end
                        else
                        begin
                            tau_reg <= drsp.quo;
                            sw_reg <= '0; i_reg <= '0;
                            state_reg <= (sweeps_reg == '0) ? S_OUT : S_V_MUL;
                        end
                    end
                S_V_MUL: begin t1_reg <= psat; state_reg <= S_V_DIV; end
                S_V_DIV: state_reg <= S_V_WAIT;
                S_V_WAIT:
                    if (drsp.done)
                    begin
                        v_reg <= drsp.quo;
                        var_reg[i_reg] <= drsp.quo;
                        j_reg <= '0; acc_reg <= '0; phase_reg <= 1'b0;
                        state_reg <= S_OFF;
                    end
                // gram row i, one read per cycle; use data for j-1
                S_OFF:
                begin
                    if ((j_reg != '0 || phase_reg) && (j_reg - COL_W'(1)) != i_reg)
                        acc_reg <= acc_reg + pfl;
                    if (phase_reg) state_reg <= S_M_MUL1;
                    phase_reg <= (j_reg == COL_W'(WEIGHT_COLS - 1)) && !phase_reg;
                    if (!phase_reg) j_reg <= j_reg + 1'b1;
                    else j_reg <= COL_W'(WEIGHT_COLS - 1) + 1'b1;
                end
                S_M_MUL1: begin t1_reg <= psat; state_reg <= S_M_MUL2; phase_reg <= 1'b0; end
                S_M_MUL2:
                begin
                    mean_reg[i_reg] <= psat;
                    if (i_reg == COL_W'(WEIGHT_COLS - 1))
                    begin
                        i_reg <= '0; state_reg <= S_X_MUL;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1; state_reg <= S_V_MUL;
                    end
                end
                S_X_MUL:
                begin
                    t1_reg <= sat48(ACC_W'(psat) + ACC_W'(var_reg[i_reg]));
                    state_reg <= S_X_DIV;
                end
                S_X_DIV: state_reg <= S_X_WAIT;
                S_X_WAIT:
                    if (drsp.done)
                    begin
                        xi_reg[i_reg] <= drsp.quo;
                        if (i_reg == COL_W'(WEIGHT_COLS - 1))
                        begin
                            i_reg <= '0; k_reg <= '0; j_reg <= '0;
                            acc_reg <= '0; acc2_reg <= '0; phase_reg <= 1'b0;
                            state_reg <= S_R_ACC;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1; state_reg <= S_X_MUL;
                        end
                    end
                // residual row k: read A[k][j] for j, data at end
                S_R_ACC:
                begin
                    if (j_reg != '0 || phase_reg) acc_reg <= acc_reg + pfl;
                    if (phase_reg)
                    begin
                        t1_reg <= sat48(ACC_W'($signed(dat_rd)) - ACC_W'(sat48(acc_reg + pfl)));
                        state_reg <= S_R_SQ;
                        phase_reg <= 1'b0;
                    end
                    else if (j_reg == COL_W'(WEIGHT_COLS - 1)) phase_reg <= 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                S_R_SQ:
                begin
                    acc2_reg <= acc2_reg + ACC_W'(psat);
                    acc_reg <= '0; j_reg <= '0;
                    if (k_reg == (ROW_W+1)'(MEAS_ROWS - 1))
                    begin
                        i_reg <= '0; acc_reg <= '0; state_reg <= S_TR;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1; state_reg <= S_R_ACC;
                    end
                end
                S_TR:
                begin
                    acc_reg <= acc_reg + pfl;
                    if (i_reg == COL_W'(WEIGHT_COLS - 1))
                    begin
                        t1_reg <= sat48(ACC_W'(lam1) + ACC_W'(qhalf(sat48(acc_reg + pfl))));
                        state_reg <= S_N_DIV;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                S_N_DIV: state_reg <= S_N_WAIT;
                S_N_WAIT:
                    if (drsp.done)
                    begin
                        tau_reg <= drsp.quo;
                        i_reg <= '0;
                        sw_reg <= sw_reg + 1'b1;
                        if (sw_reg + 10'd1 == sweeps_reg)
                        begin
                            k_reg <= '0; state_reg <= S_OUT;
                        end
                        else state_reg <= S_V_MUL;
                    end
                S_OUT:
                begin
                    if (!m_axis_tvalid || m_axis_tready)
                    begin
                        if (k_reg == (ROW_W+1)'(2 * WEIGHT_COLS))
                        begin
                            m_axis_tvalid <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tuser <= k_reg[COL_W];
                            m_axis_tlast <= (k_reg == (ROW_W+1)'(2 * WEIGHT_COLS - 1));
                            m_axis_tdata <= {4'd0,
                                k_reg[COL_W] ? var_reg[k_reg[COL_W-1:0]]
                                             : mean_reg[k_reg[COL_W-1:0]],
                                k_reg[COL_W-1:0]};
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sbmf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sbmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/sbmf_div.sv
// Radix-2 restoring divider: sat((num << 16) / den), truncated toward zero.
// Depends on sbmf_pkg.
`default_nettype none
module sbmf_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  sbmf_pkg::div_req_t    req,
    output sbmf_pkg::div_rsp_t    rsp
);
    import sbmf_pkg::*;

    logic [47:0] rem_reg;
    logic [47:0] quo_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        nneg_reg;
    logic        zero_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [48:0] trial;
    logic [47:0] shifted;
    logic [47:0] nabs;
    logic [31:0] dabs;
    logic signed [48:0] sq;
    logic signed [31:0] quo_out;

    always_comb
    begin
        nabs = req.num[31] ? 48'(-{{16{req.num[31]}}, req.num}) : 48'(req.num);
        nabs = nabs << 16;
        dabs = req.den[31] ? 32'(-req.den) : 32'(req.den);
        shifted = {rem_reg[46:0], quo_reg[47]};
        trial = {1'b0, shifted} - {17'd0, den_reg};
        sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (zero_reg) quo_out = nneg_reg ? QMINV : QMAXV;
        else if (sq > 49'sh7fffffff) quo_out = QMAXV;
        else if (sq < -49'sh80000000) quo_out = QMINV;
        else quo_out = sq[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= '0;
                quo_reg  <= nabs;
                den_reg  <= dabs;
                neg_reg  <= req.num[31] ^ req.den[31];
                nneg_reg <= req.num[31];
                zero_reg <= (req.den == '0);
                cnt_reg  <= 6'd48;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (trial[48])
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial[47:0];
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_out;
endmodule
`default_nettype wire

>>> hw/rtl/sbmf_checker.sv
// Port-level checker for the mean-field solver core, with its bind.
// Depends on the macros header.
`default_nettype none
`include "sparse_bayes_mean_field_solver_core_macros.svh"
module sbmf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tlast,
    input wire logic m_axis_tuser
);
    `SBMF_ASSERT_IMP(no_in_while_out, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `SBMF_ASSERT_IMP(last_is_var, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    `SBMF_ASSERT_NEXT(out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind sparse_bayes_mean_field_solver_core sbmf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser));
`default_nettype wire

>>> tb/sparse_bayes_mean_field_solver_core_tb.sv
// Self-checking testbench for the mean-field sparse Bayesian solver core.
// Depends on sbmf_pkg and sparse_bayes_mean_field_solver_core.
`default_nettype none
module sparse_bayes_mean_field_solver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbmf_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [1:0]  req;
        logic [4:0]  row;
        logic [3:0]  col;
        logic [31:0] val;
    } load_item_t;

    typedef struct {
        logic        kind;
        logic [3:0]  idx;
        logic [31:0] value;
        logic        last;
    } estimate_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    sparse_bayes_mean_field_solver_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    load_item_t pending_loads[$];
    estimate_t  pending_estimates[$];
    int         errors = 0;
    int         send_idle = 0;
    int         recv_stall = 0;
    int         hold_cnt = 0;
    bit         hold_armed = 0;
    bit         in_fire = 0;
    longint     cycles = 0;

    // predictor state
    int     mdl_a[MEAS_ROWS*WEIGHT_COLS];
    int     mdl_y[MEAS_ROWS];
    int     mdl_gram[WEIGHT_COLS*WEIGHT_COLS];
    int     mdl_proj[WEIGHT_COLS];
    int     mdl_mean[WEIGHT_COLS];
    int     mdl_var[WEIGHT_COLS];
    int     mdl_xi[WEIGHT_COLS];
    int     mdl_tau;
    longint prior_wshape = 65536, prior_wrate = 65536;
    longint prior_nshape = 65536, prior_nrate = 65536;
    int     mdl_sweeps = 64;

    function automatic int sat32(longint x);
        if (x > 64'sh7fffffff) return 32'sh7fffffff;
        if (x < -64'sh80000000) return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic longint fmul(int a, int b);
        return (longint'(a) * longint'(b)) >>> 16;
    endfunction

    function automatic int qmul(int a, int b);
        return sat32(fmul(a, b));
    endfunction

    function automatic int qdiv(int n, int d);
        if (d == 0) return (n >= 0) ? 32'sh7fffffff : 32'sh80000000;
        return sat32((longint'(n) * 65536) / longint'(d));
    endfunction

    // full start: Gram setup, sweeps, then queue every mean and variance
    task automatic solve_posterior();
        int     alpha, nu, v, ex2, res, lam;
        longint acc, off, mess, tr;
        estimate_t e;
        alpha = sat32(prior_wshape + 32768);
        nu = sat32(prior_nshape + 32768 * MEAS_ROWS);
        for (int i = 0; i < WEIGHT_COLS; i++) begin
            for (int j = 0; j < WEIGHT_COLS; j++) begin
                acc = 0;
                for (int r = 0; r < MEAS_ROWS; r++)
                    acc += fmul(mdl_a[r*WEIGHT_COLS+i], mdl_a[r*WEIGHT_COLS+j]);
                mdl_gram[i*WEIGHT_COLS+j] = sat32(acc);
            end
            acc = 0;
            for (int r = 0; r < MEAS_ROWS; r++)
                acc += fmul(mdl_a[r*WEIGHT_COLS+i], mdl_y[r]);
            mdl_proj[i] = sat32(acc);
            mdl_mean[i] = 0;
            mdl_var[i] = 65536;
            mdl_xi[i] = qdiv(int'(prior_wshape), int'(prior_wrate));
        end
        mdl_tau = qdiv(int'(prior_nshape), int'(prior_nrate));
        for (int it = 0; it < mdl_sweeps; it++) begin
            mess = 0;
            tr = 0;
            for (int i = 0; i < WEIGHT_COLS; i++) begin
                v = qdiv(65536, sat32(longint'(mdl_xi[i])
                        + qmul(mdl_tau, mdl_gram[i*WEIGHT_COLS+i])));
                mdl_var[i] = v;
                off = 0;
                for (int j = 0; j < WEIGHT_COLS; j++)
                    if (j != i) off += fmul(mdl_gram[i*WEIGHT_COLS+j], mdl_mean[j]);
                mdl_mean[i] = qmul(qmul(mdl_tau, v),
                        sat32(longint'(mdl_proj[i]) - longint'(sat32(off))));
            end
            for (int i = 0; i < WEIGHT_COLS; i++) begin
                ex2 = sat32(longint'(qmul(mdl_mean[i], mdl_mean[i])) + mdl_var[i]);
                mdl_xi[i] = qdiv(alpha, sat32(prior_wrate + (ex2 >>> 1)));
            end
            for (int r = 0; r < MEAS_ROWS; r++) begin
                acc = 0;
                for (int j = 0; j < WEIGHT_COLS; j++)
                    acc += fmul(mdl_a[r*WEIGHT_COLS+j], mdl_mean[j]);
                res = sat32(longint'(mdl_y[r]) - longint'(sat32(acc)));
                mess += qmul(res, res);
            end
            for (int i = 0; i < WEIGHT_COLS; i++)
                tr += fmul(mdl_gram[i*WEIGHT_COLS+i], mdl_var[i]);
            lam = sat32(prior_nrate + (sat32(mess) >>> 1));
            lam = sat32(longint'(lam) + (sat32(tr) >>> 1));
            mdl_tau = qdiv(nu, lam);
        end
        for (int k = 0; k < 2*WEIGHT_COLS; k++) begin
            e.kind = (k >= WEIGHT_COLS);
            e.idx = 4'(k % WEIGHT_COLS);
            e.value = e.kind ? mdl_var[k % WEIGHT_COLS] : mdl_mean[k % WEIGHT_COLS];
            e.last = (k == 2*WEIGHT_COLS-1);
            pending_estimates.push_back(e);
        end
    endtask

    task automatic apply_item(logic [47:0] d);
        logic [1:0]  req;
        logic [4:0]  row;
        logic [3:0]  col;
        req = d[1:0];
        row = d[6:2];
        col = d[10:7];
        if (req == REQ_MATRIX) mdl_a[row*WEIGHT_COLS+col] = int'(d[42:11]);
        else if (req == REQ_DATA) mdl_y[row] = int'(d[42:11]);
        else if (req == REQ_START) solve_posterior();
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sparse_bayes_mean_field_solver_core_tb: errors");
            $finish;
        end
    end

    // input side: accept, predict
    always @(posedge clk)
    begin
        in_fire <= s_axis_tvalid && s_axis_tready && rst_n;
        if (rst_n && s_axis_tvalid && s_axis_tready) apply_item(s_axis_tdata);
    end

    always @(negedge clk)
    begin
        load_item_t it;
        if (!rst_n) s_axis_tvalid <= 0;
        else if (!s_axis_tvalid || in_fire)
        begin
            if (pending_loads.size() > 0 && $urandom_range(0, 99) >= send_idle)
            begin
                it = pending_loads.pop_front();
                s_axis_tdata <= {5'b0, it.val, it.col, it.row, it.req};
                s_axis_tvalid <= 1;
            end
            else s_axis_tvalid <= 0;
        end
    end

    // output side: random stall plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_armed && m_axis_tvalid)
        begin
            hold_armed <= 0;
            hold_cnt <= HOLD_CYCLES;
            m_axis_tready <= 0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 0;
        end
        else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        estimate_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_estimates.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d idx=%0d value=%h last=%0d", $time,
                         m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast);
                errors++;
            end
            else
            begin
                e = pending_estimates.pop_front();
                if (m_axis_tuser !== e.kind || m_axis_tdata[3:0] !== e.idx
                    || m_axis_tdata[35:4] !== e.value || m_axis_tlast !== e.last)
                begin
                    $display("%0t: mismatch expected kind=%0d idx=%0d value=%h last=%0d",
                             $time, e.kind, e.idx, e.value, e.last);
                    $display("%0t:          actual   kind=%0d idx=%0d value=%h last=%0d",
                             $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4],
                             m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'h0;
            default: return 32'($urandom_range(0, 262143)) - 32'd131072;
        endcase
    endfunction

    task automatic push_load(logic [1:0] req, int row, int col, logic [31:0] val);
        load_item_t it;
        it.req = req;
        it.row = 5'(row);
        it.col = 4'(col);
        it.val = val;
        pending_loads.push_back(it);
    endtask

    task automatic push_random_loads(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_load(REQ_DATA, $urandom_range(0, 31), $urandom_range(0, 15), pick_value());
            else
                push_load(REQ_MATRIX, $urandom_range(0, 31), $urandom_range(0, 15),
                          pick_value());
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            CFG_WSHAPE: prior_wshape = val;
            CFG_WRATE:  prior_wrate = val;
            CFG_NSHAPE: prior_nshape = val;
            CFG_NRATE:  prior_nrate = val;
            CFG_SWEEPS: mdl_sweeps = int'(val[9:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_loads.size() > 0 || s_axis_tvalid || pending_estimates.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: unused code, extremes, every element written, zero sweeps
        write_reg(CFG_SWEEPS, 31'd0);
        push_load(2'd3, 31, 15, 32'hffffffff);
        push_load(REQ_MATRIX, 0, 0, 32'h7fffffff);
        push_load(REQ_MATRIX, 31, 15, 32'h80000000);
        for (int r = 0; r < MEAS_ROWS; r++)
        begin
            for (int c = 0; c < WEIGHT_COLS; c++)
                if (!(r == 0 && c == 0) && !(r == 31 && c == 15))
                    push_load(REQ_MATRIX, r, c, pick_value());
            push_load(REQ_DATA, r, 0, pick_value());
        end
        push_load(REQ_START, 0, 0, 32'h0);
        drain();
        write_reg(CFG_SWEEPS, 31'd1);
        push_random_loads(10);
        push_load(REQ_START, 31, 15, 32'hffffffff);
        drain();

        // sender idles, priors at the extremes
        send_idle = 70;
        write_reg(CFG_WSHAPE, 31'h7fffffff);
        write_reg(CFG_WRATE, 31'd1);
        write_reg(CFG_NSHAPE, 31'h7fffffff);
        write_reg(CFG_NRATE, 31'd1);
        write_reg(CFG_SWEEPS, 31'd2);
        push_random_loads(40);
        push_load(REQ_START, $urandom_range(0, 31), $urandom_range(0, 15), $urandom);
        drain();

        // receiver stalls, with a long hold-off while loads keep coming
        send_idle = 0;
        recv_stall = 70;
        write_reg(CFG_WSHAPE, 31'd1);
        write_reg(CFG_WRATE, 31'h7fffffff);
        write_reg(CFG_NSHAPE, 31'd1);
        write_reg(CFG_NRATE, 31'h7fffffff);
        write_reg(CFG_SWEEPS, 31'd3);
        push_random_loads(30);
        push_load(REQ_START, 0, 0, 32'h0);
        push_random_loads(30);
        hold_armed = 1;
        drain();

        // both sides idle, weight priors back to the defaults, new noise priors
        send_idle = 21;
        recv_stall = 21;
        write_reg(CFG_SWEEPS, 31'd1023);
        write_reg(CFG_WSHAPE, 31'd65536);
        write_reg(CFG_WRATE, 31'd65536);
        write_reg(CFG_NSHAPE, 31'd98304);
        write_reg(CFG_NRATE, 31'd32768);
        write_reg(CFG_SWEEPS, 31'd64);
        push_random_loads(40);
        push_load(REQ_START, 0, 0, 32'h0);
        drain();

        if (errors == 0)
            $display("sparse_bayes_mean_field_solver_core_tb: clean");
        else
            $display("sparse_bayes_mean_field_solver_core_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
